[hw/rtl/assert_macros.svh]
// Assertion macros shared by the charging-bay controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define CBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that must also hold while reset is asserted.
`define CBP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/cbp_pkg.sv]
// Types, constants and codes shared by the charging-bay controller.
`timescale 1ns / 1ps

package cbp_pkg;

  // Field widths.
  localparam int unsigned CODE_W     = 12;
  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned POWER_W    = 26;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 26;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Scaling: code times full scale is below 2^SCALE_SHIFT, so a reciprocal
  // with SCALE_SHIFT fraction bits leaves an estimate at most one low.
  localparam int unsigned SCALE_SHIFT = CODE_W + SCALE_W;
  localparam int unsigned SCALE_EST_W = 21;

  // Power: centivolts times milliamps over 100.
  localparam int unsigned POWER_SHIFT = 2 * SCALE_W;
  localparam int unsigned POWER_DIV   = 100;
  localparam logic [MUL_B_W-1:0] RECIP_POWER =
    MUL_B_W'((64'd1 << POWER_SHIFT) / 64'(POWER_DIV));

  // Scaled values saturate at the top of their field.
  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

  // Configuration register reset values.
  localparam logic [CODE_W-1:0]         CURRENT_LIMIT_RST = 12'd3839;
  localparam logic signed [TEMP_W-1:0]  TEMP_LIMIT_RST    = 12'sd600;
  localparam logic [SCALE_W-1:0]        VOLTAGE_FS_RST    = 16'd25000;
  localparam logic [SCALE_W-1:0]        CURRENT_FS_RST    = 16'd32000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURRENT_LIMIT = 4'd0,
    CFG_TEMP_LIMIT    = 4'd1,
    CFG_VOLTAGE_FS    = 4'd2,
    CFG_CURRENT_FS    = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CODE_W-1:0]        current_limit;
    logic signed [TEMP_W-1:0] temp_limit;
    logic [SCALE_W-1:0]       voltage_fs;
    logic [SCALE_W-1:0]       current_fs;
  } cfg_t;

  // Bay operating mode.
  typedef enum logic [1:0] {
    MODE_FREE     = 2'd0,
    MODE_CHARGING = 2'd1,
    MODE_FAULT    = 2'd2
  } bay_mode_e;

  // Protection state seen by the datapath.
  typedef struct packed {
    bay_mode_e         mode;
    logic              relay;
    logic              fault_event;
    logic [CODE_W-1:0] held_current;
  } bay_status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_V,
    ST_REC_V,
    ST_COR_V,
    ST_MUL_I,
    ST_REC_I,
    ST_COR_I,
    ST_MUL_P,
    ST_REC_P,
    ST_COR_P,
    ST_DONE
  } ctrl_state_e;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_V,
    OP_REC_V,
    OP_COR_V,
    OP_MUL_I,
    OP_REC_I,
    OP_COR_I,
    OP_MUL_P,
    OP_REC_P,
    OP_COR_P
  } dp_op_e;

  typedef struct packed {
    logic   load_in;
    logic   load_out;
    dp_op_e op;
  } dp_cmd_t;

endpackage

[hw/rtl/cbp_cfg_if.sv]
// Configuration write channel of the charging-bay controller.
`timescale 1ns / 1ps

interface cbp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cbp_pkg::CFG_IDX_W-1:0]    index;
  logic [cbp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/cbp_in_if.sv]
// Sample input channel of the charging-bay controller.
`timescale 1ns / 1ps

interface cbp_in_if;
  logic                             valid;
  logic                             ready;
  logic [cbp_pkg::CODE_W-1:0]       adc_current;
  logic [cbp_pkg::CODE_W-1:0]       adc_voltage;
  logic signed [cbp_pkg::TEMP_W-1:0] temp_decideg;
  logic                             temp_valid;
  logic                             plugin_level;
  logic                             plugout_level;

  modport source (output valid, output adc_current, output adc_voltage,
                  output temp_decideg, output temp_valid, output plugin_level,
                  output plugout_level, input ready);
  modport sink   (input valid, input adc_current, input adc_voltage,
                  input temp_decideg, input temp_valid, input plugin_level,
                  input plugout_level, output ready);
endinterface

[hw/rtl/cbp_out_if.sv]
// Result output channel of the charging-bay controller.
`timescale 1ns / 1ps

interface cbp_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       bay_state;
  logic                             relay_on;
  logic                             led_free;
  logic                             led_charging;
  logic                             led_red;
  logic [cbp_pkg::SCALE_W-1:0]      voltage_cv;
  logic [cbp_pkg::SCALE_W-1:0]      current_ma;
  logic [cbp_pkg::POWER_W-1:0]      power_mw;
  logic                             fault_event;

  modport source (output valid, output bay_state, output relay_on, output led_free,
                  output led_charging, output led_red, output voltage_cv,
                  output current_ma, output power_mw, output fault_event, input ready);
  modport sink   (input valid, input bay_state, input relay_on, input led_free,
                  input led_charging, input led_red, input voltage_cv,
                  input current_ma, input power_mw, input fault_event, output ready);
endinterface

[hw/rtl/charge_bay_protection_controller_unit.sv]
// Top level of the charging-bay protection controller.
// Each accepted sample runs through nine steps that pass three scalings through
// the single shared multiplier, then a result load step that waits for a free
// output slot, and one idle step in which the next sample is taken.
// Reset (rst_ni low, asynchronous): bay free, relay off, both buttons armed,
// held readings zero, configuration at its defaults, no result pending.
`timescale 1ns / 1ps

module charge_bay_protection_controller_unit #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbp_cfg_if.sink   cfg_i,
  cbp_in_if.sink    in_i,
  cbp_out_if.source out_o
);

  cbp_pkg::cfg_t        cfg_q;
  cbp_pkg::dp_cmd_t     cmd;
  cbp_pkg::bay_status_t status;

  // Configuration registers; writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_limit <= cbp_pkg::CURRENT_LIMIT_RST;
      cfg_q.temp_limit    <= cbp_pkg::TEMP_LIMIT_RST;
      cfg_q.voltage_fs    <= cbp_pkg::VOLTAGE_FS_RST;
      cfg_q.current_fs    <= cbp_pkg::CURRENT_FS_RST;
    end else if (cfg_i.valid) begin
      unique case (cbp_pkg::cfg_idx_e'(cfg_i.index))
        cbp_pkg::CFG_CURRENT_LIMIT: cfg_q.current_limit <= cfg_i.data[cbp_pkg::CODE_W-1:0];
        cbp_pkg::CFG_TEMP_LIMIT:    cfg_q.temp_limit    <= cfg_i.data[cbp_pkg::TEMP_W-1:0];
        cbp_pkg::CFG_VOLTAGE_FS:    cfg_q.voltage_fs    <= cfg_i.data[cbp_pkg::SCALE_W-1:0];
        cbp_pkg::CFG_CURRENT_FS:    cfg_q.current_fs    <= cfg_i.data[cbp_pkg::SCALE_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Sequencer.
  cbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Protection state machine, stepped once per accepted beat.
  cbp_guard u_guard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (cmd.load_in),
    .adc_current_i   (in_i.adc_current),
    .temp_decideg_i  (in_i.temp_decideg),
    .temp_valid_i    (in_i.temp_valid),
    .plugin_level_i  (in_i.plugin_level),
    .plugout_level_i (in_i.plugout_level),
    .cfg_i           (cfg_q),
    .status_o        (status)
  );

  // Scaling datapath and result register.
  cbp_dp #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .adc_voltage_i  (in_i.adc_voltage),
    .status_i       (status),
    .cfg_i          (cfg_q),
    .bay_state_o    (out_o.bay_state),
    .relay_on_o     (out_o.relay_on),
    .led_free_o     (out_o.led_free),
    .led_charging_o (out_o.led_charging),
    .led_red_o      (out_o.led_red),
    .voltage_cv_o   (out_o.voltage_cv),
    .current_ma_o   (out_o.current_ma),
    .power_mw_o     (out_o.power_mw),
    .fault_event_o  (out_o.fault_event)
  );

endmodule

[hw/rtl/cbp_ctrl.sv]
// Sequencer that steps the datapath through one sample and hands off the result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cbp_pkg::dp_cmd_t  cmd_o
);

  cbp_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 slot_free;

  // The result register can take a new beat when empty or being drained.
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbp_pkg::ST_IDLE:  if (in_valid_i) state_d = cbp_pkg::ST_MUL_V;
      cbp_pkg::ST_MUL_V: state_d = cbp_pkg::ST_REC_V;
      cbp_pkg::ST_REC_V: state_d = cbp_pkg::ST_COR_V;
      cbp_pkg::ST_COR_V: state_d = cbp_pkg::ST_MUL_I;
      cbp_pkg::ST_MUL_I: state_d = cbp_pkg::ST_REC_I;
      cbp_pkg::ST_REC_I: state_d = cbp_pkg::ST_COR_I;
      cbp_pkg::ST_COR_I: state_d = cbp_pkg::ST_MUL_P;
      cbp_pkg::ST_MUL_P: state_d = cbp_pkg::ST_REC_P;
      cbp_pkg::ST_REC_P: state_d = cbp_pkg::ST_COR_P;
      cbp_pkg::ST_COR_P: state_d = cbp_pkg::ST_DONE;
      cbp_pkg::ST_DONE:  if (slot_free) state_d = cbp_pkg::ST_IDLE;
      default:           state_d = cbp_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath and the input handshake.
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.load_in  = 1'b0;
    cmd_o.load_out = 1'b0;
    cmd_o.op       = cbp_pkg::OP_NONE;
    unique case (state_q)
      cbp_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      cbp_pkg::ST_MUL_V: cmd_o.op = cbp_pkg::OP_MUL_V;
      cbp_pkg::ST_REC_V: cmd_o.op = cbp_pkg::OP_REC_V;
      cbp_pkg::ST_COR_V: cmd_o.op = cbp_pkg::OP_COR_V;
      cbp_pkg::ST_MUL_I: cmd_o.op = cbp_pkg::OP_MUL_I;
      cbp_pkg::ST_REC_I: cmd_o.op = cbp_pkg::OP_REC_I;
      cbp_pkg::ST_COR_I: cmd_o.op = cbp_pkg::OP_COR_I;
      cbp_pkg::ST_MUL_P: cmd_o.op = cbp_pkg::OP_MUL_P;
      cbp_pkg::ST_REC_P: cmd_o.op = cbp_pkg::OP_REC_P;
      cbp_pkg::ST_COR_P: cmd_o.op = cbp_pkg::OP_COR_P;
      cbp_pkg::ST_DONE:  cmd_o.load_out = slot_free;
      default: begin
        cmd_o.op = cbp_pkg::OP_NONE;
      end
    endcase
  end

  // Output beat pending flag.
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A new result never overwrites one that is still waiting.
  `CBP_ASSERT(a_load_needs_slot, cmd_o.load_out |-> (!out_valid_q || out_ready_i), "result overwritten")
  // An accepted beat always starts the voltage scaling.
  `CBP_ASSERT(a_accept_starts, (in_valid_i && in_ready_o) |=> (state_q == cbp_pkg::ST_MUL_V), "accept did not start work")
  // A finished sample with an empty slot is presented on the next cycle.
  `CBP_ASSERT(a_done_presents, (state_q == cbp_pkg::ST_DONE && !out_valid_q) |=> out_valid_q, "result not presented")

endmodule

[hw/rtl/cbp_guard.sv]
// Bay protection state: plug buttons, held readings and the fault latch.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbp_guard (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic [cbp_pkg::CODE_W-1:0]         adc_current_i,
  input  logic signed [cbp_pkg::TEMP_W-1:0]  temp_decideg_i,
  input  logic                               temp_valid_i,
  input  logic                               plugin_level_i,
  input  logic                               plugout_level_i,
  input  cbp_pkg::cfg_t                      cfg_i,
  output cbp_pkg::bay_status_t               status_o
);

  cbp_pkg::bay_mode_e               mode_q, mode_d, mode_plug, mode_sense;
  logic                             relay_q, relay_d, relay_plug;
  logic                             plugin_armed_q, plugout_armed_q;
  logic                             fault_event_q, fault_event_d;
  logic [cbp_pkg::CODE_W-1:0]       held_current_q, held_current_d;
  logic signed [cbp_pkg::TEMP_W-1:0] held_temp_q, held_temp_d;
  logic                             press_in, press_out, over_limit;
  logic                             in_fault;

  // Plug handling, sensing and fault detection for one sample, in that order.
  always_comb begin
    press_in   = !plugin_level_i && plugin_armed_q;
    press_out  = !plugout_level_i && plugout_armed_q;
    mode_plug  = mode_q;
    relay_plug = relay_q;
    if (press_in && mode_q == cbp_pkg::MODE_FREE) begin
      mode_plug  = cbp_pkg::MODE_CHARGING;
      relay_plug = 1'b1;
    end
    // Unplugging leaves the relay where it was.
    mode_sense = (press_out && mode_plug == cbp_pkg::MODE_CHARGING) ?
                 cbp_pkg::MODE_FREE : mode_plug;

    held_current_d = (mode_sense == cbp_pkg::MODE_CHARGING) ? adc_current_i : held_current_q;
    held_temp_d    = temp_valid_i ? temp_decideg_i : held_temp_q;

    over_limit = (held_current_d > cfg_i.current_limit) ||
                 ($signed(held_temp_d) > $signed(cfg_i.temp_limit));
    fault_event_d = (mode_sense == cbp_pkg::MODE_CHARGING) && over_limit;
    mode_d  = fault_event_d ? cbp_pkg::MODE_FAULT : mode_sense;
    relay_d = fault_event_d ? 1'b0 : relay_plug;
  end

  // State update once per accepted sample; a button re-arms when released.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= cbp_pkg::MODE_FREE;
      relay_q         <= 1'b0;
      plugin_armed_q  <= 1'b1;
      plugout_armed_q <= 1'b1;
      fault_event_q   <= 1'b0;
      held_current_q  <= '0;
      held_temp_q     <= '0;
    end else if (step_i) begin
      mode_q          <= mode_d;
      relay_q         <= relay_d;
      plugin_armed_q  <= plugin_level_i;
      plugout_armed_q <= plugout_level_i;
      fault_event_q   <= fault_event_d;
      held_current_q  <= held_current_d;
      held_temp_q     <= held_temp_d;
    end
  end

  assign status_o.mode         = mode_q;
  assign status_o.relay        = relay_q;
  assign status_o.fault_event  = fault_event_q;
  assign status_o.held_current = held_current_q;

  // Fault state flag for the checks below.
  assign in_fault = (mode_q == cbp_pkg::MODE_FAULT);

  // The fault is left only through reset.
  `CBP_ASSERT(a_fault_sticky, in_fault |=> in_fault, "fault state left")
  // The relay is never driven in the fault state.
  `CBP_ASSERT_ALWAYS(a_relay_off_fault, in_fault |-> !relay_q, "relay on in fault")
  // A fault event is only flagged together with the fault state.
  `CBP_ASSERT(a_event_in_fault, fault_event_q |-> in_fault, "fault event without fault")

endmodule

[hw/rtl/cbp_dp.sv]
// Scaling datapath: one shared multiplier with reciprocal division and result register.
`timescale 1ns / 1ps

module cbp_dp #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                          clk_i,
  input  cbp_pkg::dp_cmd_t              cmd_i,
  input  logic [cbp_pkg::CODE_W-1:0]    adc_voltage_i,
  input  cbp_pkg::bay_status_t          status_i,
  input  cbp_pkg::cfg_t                 cfg_i,
  output logic [1:0]                    bay_state_o,
  output logic                          relay_on_o,
  output logic                          led_free_o,
  output logic                          led_charging_o,
  output logic                          led_red_o,
  output logic [cbp_pkg::SCALE_W-1:0]   voltage_cv_o,
  output logic [cbp_pkg::SCALE_W-1:0]   current_ma_o,
  output logic [cbp_pkg::POWER_W-1:0]   power_mw_o,
  output logic                          fault_event_o
);

  localparam int unsigned SW = cbp_pkg::SCALE_W;
  localparam int unsigned EW = cbp_pkg::SCALE_EST_W;
  localparam int unsigned PW = cbp_pkg::POWER_W;
  localparam int unsigned RW = cbp_pkg::SCALE_SHIFT + 6;
  localparam int unsigned QW = EW + 1;
  localparam int unsigned XW = cbp_pkg::MUL_A_W;

  // Converter full-scale code and its reciprocal.
  localparam logic [SW-1:0] FullScale = SW'((32'd1 << ADC_BITS) - 32'd1);
  localparam logic [cbp_pkg::MUL_B_W-1:0] RecipFs =
    cbp_pkg::MUL_B_W'((64'd1 << cbp_pkg::SCALE_SHIFT) / 64'(FullScale));

  logic [cbp_pkg::CODE_W-1:0]      rv_q;
  logic [XW-1:0]                   x_q;
  logic [cbp_pkg::PROD_W-1:0]      prod_q, prod;
  logic [XW-1:0]                   mul_a;
  logic [cbp_pkg::MUL_B_W-1:0]     mul_b;
  logic [SW-1:0]                   v_q, i_q;
  logic [PW-1:0]                   p_q;

  logic [EW-1:0]                   sc_est;
  logic [RW-1:0]                   sc_back, sc_rem;
  logic [QW-1:0]                   sc_quot;
  logic [SW-1:0]                   sc_sat;
  logic [PW-1:0]                   pw_est, pw_quot;
  logic [XW:0]                     pw_back, pw_rem;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      cbp_pkg::OP_MUL_V: begin
        mul_a = XW'(rv_q);
        mul_b = cbp_pkg::MUL_B_W'(cfg_i.voltage_fs);
      end
      cbp_pkg::OP_MUL_I: begin
        mul_a = XW'(status_i.held_current);
        mul_b = cbp_pkg::MUL_B_W'(cfg_i.current_fs);
      end
      cbp_pkg::OP_MUL_P: begin
        mul_a = XW'(v_q);
        mul_b = cbp_pkg::MUL_B_W'(i_q);
      end
      cbp_pkg::OP_REC_V, cbp_pkg::OP_REC_I: begin
        mul_a = x_q;
        mul_b = RecipFs;
      end
      cbp_pkg::OP_REC_P: begin
        mul_a = x_q;
        mul_b = cbp_pkg::RECIP_POWER;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = {{cbp_pkg::MUL_B_W{1'b0}}, mul_a} * {{XW{1'b0}}, mul_b};

  // Scale correction: the reciprocal estimate is at most one low.
  // The full scale is 2^ADC_BITS - 1, so estimate times it is a shift and subtract.
  always_comb begin
    sc_est  = prod_q[cbp_pkg::SCALE_SHIFT +: EW];
    sc_back = (RW'(sc_est) << ADC_BITS) - RW'(sc_est);
    sc_rem  = RW'(x_q) - sc_back;
    sc_quot = QW'(sc_est) + QW'(sc_rem >= RW'(FullScale));
    sc_sat  = (sc_quot > QW'(cbp_pkg::SCALE_MAX)) ? cbp_pkg::SCALE_MAX : sc_quot[SW-1:0];
  end

  // Power correction against the divisor of 100.
  always_comb begin
    pw_est  = prod_q[cbp_pkg::POWER_SHIFT +: PW];
    pw_back = (XW+1)'(pw_est) * (XW+1)'(cbp_pkg::POWER_DIV);
    pw_rem  = (XW+1)'(x_q) - pw_back;
    pw_quot = pw_est + PW'(pw_rem >= (XW+1)'(cbp_pkg::POWER_DIV));
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      rv_q <= adc_voltage_i;
    end
    unique case (cmd_i.op)
      cbp_pkg::OP_MUL_V, cbp_pkg::OP_MUL_I, cbp_pkg::OP_MUL_P: x_q <= prod[XW-1:0];
      cbp_pkg::OP_REC_V, cbp_pkg::OP_REC_I, cbp_pkg::OP_REC_P: prod_q <= prod;
      cbp_pkg::OP_COR_V: v_q <= sc_sat;
      cbp_pkg::OP_COR_I: i_q <= sc_sat;
      cbp_pkg::OP_COR_P: p_q <= pw_quot;
      default: begin
        x_q <= x_q;
      end
    endcase
  end

  // Result register, loaded when the output slot is free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      bay_state_o    <= status_i.mode;
      relay_on_o     <= status_i.relay;
      led_free_o     <= (status_i.mode == cbp_pkg::MODE_FREE);
      led_charging_o <= (status_i.mode == cbp_pkg::MODE_CHARGING);
      led_red_o      <= (status_i.mode != cbp_pkg::MODE_FREE) &&
                        (status_i.mode != cbp_pkg::MODE_CHARGING);
      voltage_cv_o   <= v_q;
      current_ma_o   <= i_q;
      power_mw_o     <= p_q;
      fault_event_o  <= status_i.fault_event;
    end
  end

endmodule
